// File: design/skfi_pkg.sv
// Package for the sorted key store: sizes, the cell data record and the
// search result record. Used by every module of the block; no dependencies.
`default_nettype none

package skfi_pkg;

  localparam int Capacity = 256;
  localparam int KeyW     = 160;
  localparam int HandleW  = 8;
  localparam int PosW     = 9;
  localparam int CountW   = $clog2(Capacity + 1);
  localparam int IdxW     = $clog2(Capacity + 1);

  // Cells are OR-reduced in groups; the group results are registered.
  localparam int GroupSize = 16;
  localparam int NumGroups = (Capacity + GroupSize - 1) / GroupSize;

  localparam logic OP_FIND   = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic               valid;
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] handle;
  } cell_t;

  typedef struct packed {
    logic               found;
    logic [IdxW-1:0]    position;
    logic [HandleW-1:0] handle;
  } search_t;

endpackage

`default_nettype wire

// File: design/skfi_cell.sv
// One storage cell of the sorted key chain: a key, its handle and a valid
// bit, plus the registered compare flags. Depends on skfi_pkg.
`default_nettype none

module skfi_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cmp_en_i,
  input  wire logic                          ins_en_i,
  input  wire logic [skfi_pkg::KeyW-1:0]     key_i,
  input  wire logic [skfi_pkg::HandleW-1:0]  handle_new_i,
  input  wire skfi_pkg::cell_t               prev_i,
  input  wire logic                          prev_below_i,
  output      skfi_pkg::cell_t               data_o,
  output      logic                          below_o,
  output      logic                          equal_o
);

  logic                         valid_q, valid_d;
  logic [skfi_pkg::KeyW-1:0]    key_q, key_d;
  logic [skfi_pkg::HandleW-1:0] handle_q, handle_d;
  logic                         below_q, below_d;
  logic                         equal_q, equal_d;
  logic                         load;

  // Cells below the key keep their entry. The first cell not below it takes
  // the new key; every cell above that takes its lower neighbor's entry.
  assign load = ins_en_i && !below_q;

  always_comb begin
    below_d = below_q;
    equal_d = equal_q;
    if (cmp_en_i) begin
      below_d = valid_q && (key_q < key_i);
      equal_d = valid_q && (key_q == key_i);
    end
  end

  always_comb begin
    valid_d  = valid_q;
    key_d    = key_q;
    handle_d = handle_q;
    if (load) begin
      if (prev_below_i) begin
        valid_d  = 1'b1;
        key_d    = key_i;
        handle_d = handle_new_i;
      end else begin
        valid_d  = prev_i.valid;
        key_d    = prev_i.key;
        handle_d = prev_i.handle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      below_q <= 1'b0;
      equal_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      below_q <= below_d;
      equal_q <= equal_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    handle_q <= handle_d;
  end

  assign data_o.valid  = valid_q;
  assign data_o.key    = key_q;
  assign data_o.handle = handle_q;
  assign below_o       = below_q;
  assign equal_o       = equal_q;

endmodule

`default_nettype wire

// File: design/skfi_reduce.sv
// Registered OR tree over the cell flags: finds the matching cell's handle
// and the sorted position of the key. Depends on skfi_pkg.
`default_nettype none

module skfi_reduce (
  input  wire logic                                                 clk_i,
  input  wire logic                                                 rst_ni,
  input  wire logic [skfi_pkg::Capacity-1:0]                        below_i,
  input  wire logic [skfi_pkg::Capacity-1:0]                        equal_i,
  input  wire logic [skfi_pkg::Capacity-1:0][skfi_pkg::HandleW-1:0] handle_i,
  output      skfi_pkg::search_t                                    result_o
);

  logic [skfi_pkg::Capacity-1:0]                         edge_flag;
  logic [skfi_pkg::NumGroups-1:0]                        grp_eq_d, grp_eq_q;
  logic [skfi_pkg::NumGroups-1:0][skfi_pkg::IdxW-1:0]    grp_pos_d, grp_pos_q;
  logic [skfi_pkg::NumGroups-1:0][skfi_pkg::HandleW-1:0] grp_hdl_d, grp_hdl_q;
  logic                                                  all_below_q;

  // The cells below the key form a prefix, so the insertion point is the
  // single cell where that prefix ends.
  always_comb begin
    for (int i = 0; i < skfi_pkg::Capacity; i++) begin
      if (i == 0) begin
        edge_flag[i] = !below_i[i];
      end else begin
        edge_flag[i] = !below_i[i] && below_i[i-1];
      end
    end
  end

  always_comb begin
    for (int g = 0; g < skfi_pkg::NumGroups; g++) begin
      grp_eq_d[g]  = 1'b0;
      grp_pos_d[g] = '0;
      grp_hdl_d[g] = '0;
      for (int j = 0; j < skfi_pkg::GroupSize; j++) begin
        if (g * skfi_pkg::GroupSize + j < skfi_pkg::Capacity) begin
          grp_eq_d[g] = grp_eq_d[g] | equal_i[g*skfi_pkg::GroupSize+j];
          if (edge_flag[g*skfi_pkg::GroupSize+j]) begin
            grp_pos_d[g] = grp_pos_d[g]
                         | skfi_pkg::IdxW'(g * skfi_pkg::GroupSize + j);
          end
          if (equal_i[g*skfi_pkg::GroupSize+j]) begin
            grp_hdl_d[g] = grp_hdl_d[g] | handle_i[g*skfi_pkg::GroupSize+j];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_eq_q    <= '0;
      all_below_q <= 1'b0;
    end else begin
      grp_eq_q    <= grp_eq_d;
      all_below_q <= below_i[skfi_pkg::Capacity-1];
    end
  end

  always_ff @(posedge clk_i) begin
    grp_pos_q <= grp_pos_d;
    grp_hdl_q <= grp_hdl_d;
  end

  always_comb begin
    result_o.found    = 1'b0;
    result_o.position = '0;
    result_o.handle   = '0;
    for (int g = 0; g < skfi_pkg::NumGroups; g++) begin
      result_o.found    = result_o.found | grp_eq_q[g];
      result_o.position = result_o.position | grp_pos_q[g];
      result_o.handle   = result_o.handle | grp_hdl_q[g];
    end
    if (all_below_q) begin
      result_o.position = skfi_pkg::IdxW'(skfi_pkg::Capacity);
    end
  end

  // Stored keys are unique, so at most one cell can match.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(equal_i))
    else $error("more than one cell matches the key");

  // The insertion point is unique unless every cell lies below the key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $onehot0(edge_flag) && (below_i[skfi_pkg::Capacity-1] ? edge_flag == '0
                                                                          : 1'b1))
    else $error("insertion boundary is not unique");

  // A matching cell never lies below the key.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (equal_i & below_i) == '0)
    else $error("cell flagged both below and equal");

endmodule

`default_nettype wire

// File: design/sorted_key_find_or_insert_top.sv
// Sorted key store with find and find-or-insert: a chain of 256 key cells, an
// OR-tree search stage, the entry counter and the result register.
// Depends on skfi_pkg, skfi_cell and skfi_reduce.
//
// A transaction is accepted only while the block is idle. The key is latched
// at acceptance. In the compare state every cell compares it against its
// entry in parallel. In the reduce state the registered OR tree resolves the
// match and the insertion point. In the finish state the result register
// loads while, on an insert, the cells at and above the insertion point shift
// up by one in a single step. That last step waits for as long as an earlier
// result is held by the receiver. The next key is accepted in the cycle after
// the result register loads, even while that result is still stalled. Reset
// empties the store at once through the cell valid bits; no clearing pass is
// needed. Position is the index of the key or its insertion point (256 when it
// belongs after a full table). The handle of a new key is the entry count
// before it was inserted.
`default_nettype none

module sorted_key_find_or_insert_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire logic                           operation_i,
  input  wire logic [63:0]                    key_upper_i,
  input  wire logic [63:0]                    key_middle_i,
  input  wire logic [31:0]                    key_lower_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic                           found_o,
  output      logic                           inserted_o,
  output      logic                           full_error_o,
  output      logic [skfi_pkg::PosW-1:0]      position_o,
  output      logic [skfi_pkg::HandleW-1:0]   handle_o,
  output      logic [skfi_pkg::PosW-1:0]      entry_total_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CMP    = 2'd1;
  localparam logic [1:0] ST_REDUCE = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]                     state_q, state_d;
  logic                           op_q;
  logic [skfi_pkg::KeyW-1:0]      key_q;
  logic [skfi_pkg::CountW-1:0]    count_q, count_d;
  logic                           accept;
  logic                           finish;
  logic                           table_full;
  logic                           ins_en;
  logic                           cmp_en;
  skfi_pkg::search_t              search;

  logic                           out_valid_q, out_valid_d;
  logic                           found_q, inserted_q, full_error_q;
  logic [skfi_pkg::PosW-1:0]      position_q, entry_total_q;
  logic [skfi_pkg::HandleW-1:0]   handle_q;

  skfi_pkg::cell_t [skfi_pkg::Capacity-1:0]                 cell_data;
  logic [skfi_pkg::Capacity-1:0]                            cell_below;
  logic [skfi_pkg::Capacity-1:0]                            cell_equal;
  logic [skfi_pkg::Capacity-1:0][skfi_pkg::HandleW-1:0]     cell_handle;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign finish     = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);
  assign cmp_en     = (state_q == ST_CMP);
  assign table_full = (count_q == skfi_pkg::CountW'(skfi_pkg::Capacity));
  assign ins_en     = finish && (op_q == skfi_pkg::OP_INSERT) && !search.found
                      && !table_full;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept) state_d = ST_CMP;
      ST_CMP:    state_d = ST_REDUCE;
      ST_REDUCE: state_d = ST_FINISH;
      ST_FINISH: if (finish) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= operation_i;
      key_q <= {key_upper_i, key_middle_i, key_lower_i};
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < skfi_pkg::Capacity; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        skfi_cell u_cell (
          .clk_i        (clk_i),
          .rst_ni       (rst_ni),
          .cmp_en_i     (cmp_en),
          .ins_en_i     (ins_en),
          .key_i        (key_q),
          .handle_new_i (count_q[skfi_pkg::HandleW-1:0]),
          .prev_i       ('0),
          .prev_below_i (1'b1),
          .data_o       (cell_data[gi]),
          .below_o      (cell_below[gi]),
          .equal_o      (cell_equal[gi])
        );
      end else begin : g_rest
        skfi_cell u_cell (
          .clk_i        (clk_i),
          .rst_ni       (rst_ni),
          .cmp_en_i     (cmp_en),
          .ins_en_i     (ins_en),
          .key_i        (key_q),
          .handle_new_i (count_q[skfi_pkg::HandleW-1:0]),
          .prev_i       (cell_data[gi-1]),
          .prev_below_i (cell_below[gi-1]),
          .data_o       (cell_data[gi]),
          .below_o      (cell_below[gi]),
          .equal_o      (cell_equal[gi])
        );
      end
      assign cell_handle[gi] = cell_data[gi].handle;
    end
  endgenerate

  skfi_reduce u_reduce (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .below_i  (cell_below),
    .equal_i  (cell_equal),
    .handle_i (cell_handle),
    .result_o (search)
  );

  assign count_d = ins_en ? count_q + skfi_pkg::CountW'(1) : count_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      found_q       <= search.found;
      inserted_q    <= ins_en;
      full_error_q  <= (op_q == skfi_pkg::OP_INSERT) && !search.found && table_full;
      position_q    <= search.position[skfi_pkg::PosW-1:0];
      entry_total_q <= count_d[skfi_pkg::PosW-1:0];
      if (search.found) begin
        handle_q <= search.handle;
      end else if (ins_en) begin
        handle_q <= count_q[skfi_pkg::HandleW-1:0];
      end else begin
        handle_q <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign inserted_o    = inserted_q;
  assign full_error_o  = full_error_q;
  assign position_o    = position_q;
  assign handle_o      = handle_q;
  assign entry_total_o = entry_total_q;

  // The entry count never passes the number of cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   count_q <= skfi_pkg::CountW'(skfi_pkg::Capacity))
    else $error("entry count exceeds capacity");

  // An insert grows the table by exactly one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   ins_en |=> count_q == $past(count_q) + skfi_pkg::CountW'(1))
    else $error("insert did not advance the entry count");

  // A result never reports found together with inserted or a full error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o |-> !(found_o && (inserted_o || full_error_o))
                                   && !(inserted_o && full_error_o))
    else $error("conflicting result flags");

  // The cells hold still while a transaction is being resolved.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == ST_REDUCE) |=> $stable(cell_below) && $stable(cell_equal))
    else $error("cell flags changed during the search");

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for sorted_key_find_or_insert_top: directed and random lookups,
// checked against a sorted key store model kept in the testbench.
// Depends on skfi_pkg and the design sources.

module testbench;

  localparam int RandomLookups = 1800;
  localparam int ChunkSize     = 150;
  localparam int LongHold      = 80;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 20;

  typedef struct packed {
    logic        op;
    logic [63:0] upper;
    logic [63:0] middle;
    logic [31:0] lower;
  } lookup_t;

  typedef struct packed {
    logic                         found;
    logic                         inserted;
    logic                         full_error;
    logic [skfi_pkg::PosW-1:0]    position;
    logic [skfi_pkg::HandleW-1:0] handle;
    logic [skfi_pkg::PosW-1:0]    entry_total;
  } lookup_result_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        operation_i  = skfi_pkg::OP_FIND;
  logic [63:0] key_upper_i  = '0;
  logic [63:0] key_middle_i = '0;
  logic [31:0] key_lower_i  = '0;
  logic        out_stall_i  = 1'b0;

  logic                         in_stall_o;
  logic                         out_valid_o;
  logic                         found_o;
  logic                         inserted_o;
  logic                         full_error_o;
  logic [skfi_pkg::PosW-1:0]    position_o;
  logic [skfi_pkg::HandleW-1:0] handle_o;
  logic [skfi_pkg::PosW-1:0]    entry_total_o;

  sorted_key_find_or_insert_top u_dut (.*);

  // Model of the store: keys in ascending order with their handles.
  logic [skfi_pkg::KeyW-1:0]    model_key [skfi_pkg::Capacity];
  logic [skfi_pkg::HandleW-1:0] model_handle [skfi_pkg::Capacity];
  int                           model_count = 0;

  lookup_t                   pending_lookups [$];
  lookup_result_t            predicted_results [$];
  logic [skfi_pkg::KeyW-1:0] key_pool [$];
  logic [63:0]               shared_prefix [4];

  lookup_t drv_lookup;
  bit      in_taken = 1'b0;
  bit      idle_on = 1'b1;
  int      tx_gap_left = 0;
  int      rx_gap_left = 0;
  int      rx_hold_left = 0;
  int      long_hold_reqs = 0;
  int      long_hold_done = 0;
  int      lookups_queued = 0;
  int      lookups_accepted = 0;
  int      mismatch_count = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic lookup_result_t store_lookup(lookup_t req);
    lookup_result_t r;
    logic [skfi_pkg::KeyW-1:0] key;
    int pos;
    key = {req.upper, req.middle, req.lower};
    r = '0;
    pos = 0;
    while (pos < model_count && model_key[pos] < key) pos++;
    if (pos < model_count && model_key[pos] == key) begin
      r.found = 1'b1;
      r.handle = model_handle[pos];
    end else if (req.op == skfi_pkg::OP_INSERT) begin
      if (model_count >= skfi_pkg::Capacity) begin
        r.full_error = 1'b1;
      end else begin
        for (int i = model_count; i > pos; i--) begin
          model_key[i] = model_key[i-1];
          model_handle[i] = model_handle[i-1];
        end
        model_key[pos] = key;
        model_handle[pos] = skfi_pkg::HandleW'(model_count);
        r.handle = skfi_pkg::HandleW'(model_count);
        r.inserted = 1'b1;
        model_count++;
      end
    end
    r.position = skfi_pkg::PosW'(pos);
    r.entry_total = skfi_pkg::PosW'(model_count);
    return r;
  endfunction

  // Words drawn from a few shared values so that keys often tie on a prefix.
  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2, 3: return shared_prefix[$urandom_range(0, 3)];
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [skfi_pkg::KeyW-1:0] make_key();
    logic [skfi_pkg::KeyW-1:0] k;
    int pick;
    pick = $urandom_range(0, 9);
    if (key_pool.size() == 0 || pick >= 6) begin
      k = {pick_word(), pick_word(), 32'($urandom)};
    end else begin
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      case (pick)
        3: k[31:0] = k[31:0] + 32'd1;
        4: k[31:0] = k[31:0] - 32'd1;
        5: k[95:32] = pick_word();
        default: ;
      endcase
    end
    // The all-ones key stays out of the store so that it can land past a full table.
    if (k == '1) k[0] = 1'b0;
    return k;
  endfunction

  task automatic push_lookup(input logic op, input logic [skfi_pkg::KeyW-1:0] key);
    lookup_t t;
    t.op = op;
    t.upper = key[159:96];
    t.middle = key[95:32];
    t.lower = key[31:0];
    pending_lookups.push_back(t);
    lookups_queued++;
    if (op == skfi_pkg::OP_INSERT) key_pool.push_back(key);
  endtask

  task automatic wait_idle();
    while (!(lookups_accepted == lookups_queued && predicted_results.size() == 0))
      @(posedge clk_i);
  endtask

  // Sender: a new transaction is offered only once the previous one was taken.
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      in_taken = 1'b0;
      if (tx_gap_left > 0) begin
        tx_gap_left--;
        in_valid_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        tx_gap_left = $urandom_range(0, 3);
        in_valid_i <= 1'b0;
      end else if (rst_ni && pending_lookups.size() > 0) begin
        drv_lookup = pending_lookups.pop_front();
        in_valid_i <= 1'b1;
        operation_i <= drv_lookup.op;
        key_upper_i <= drv_lookup.upper;
        key_middle_i <= drv_lookup.middle;
        key_lower_i <= drv_lookup.lower;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predicted_results.push_back(store_lookup(drv_lookup));
      lookups_accepted++;
      in_taken = 1'b1;
    end
  end

  // Receiver: short random stalls, plus a long hold on request.
  always @(negedge clk_i) begin
    if (long_hold_done != long_hold_reqs) begin
      long_hold_done++;
      rx_hold_left = LongHold;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall_i <= 1'b1;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rx_gap_left = $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_results.size() == 0) begin
        $error("result transaction with no lookup outstanding");
        mismatch_count++;
      end else begin
        want = predicted_results.pop_front();
        if (found_o !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, found_o);
          mismatch_count++;
        end
        if (inserted_o !== want.inserted) begin
          $error("inserted: expected %0d, actual %0d", want.inserted, inserted_o);
          mismatch_count++;
        end
        if (full_error_o !== want.full_error) begin
          $error("full_error: expected %0d, actual %0d", want.full_error, full_error_o);
          mismatch_count++;
        end
        if (position_o !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, position_o);
          mismatch_count++;
        end
        if (handle_o !== want.handle) begin
          $error("handle: expected %0d, actual %0d", want.handle, handle_o);
          mismatch_count++;
        end
        if (entry_total_o !== want.entry_total) begin
          $error("entry_total: expected %0d, actual %0d", want.entry_total, entry_total_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck = 0;
      else stuck++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    logic [skfi_pkg::KeyW-1:0] mid_key;
    logic [skfi_pkg::KeyW-1:0] top_key;
    int random_done;
    int chunk;
    bit full_checked;
    for (int i = 0; i < 4; i++) shared_prefix[i] = {$urandom, $urandom};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    mid_key = {shared_prefix[0], shared_prefix[1], 32'($urandom)};
    top_key = '1;
    push_lookup(skfi_pkg::OP_FIND, '0);
    push_lookup(skfi_pkg::OP_FIND, top_key);
    push_lookup(skfi_pkg::OP_INSERT, mid_key);
    push_lookup(skfi_pkg::OP_INSERT, '0);
    push_lookup(skfi_pkg::OP_FIND, '0);
    push_lookup(skfi_pkg::OP_INSERT, mid_key);
    push_lookup(skfi_pkg::OP_INSERT, mid_key + 1);
    push_lookup(skfi_pkg::OP_INSERT, mid_key - 1);
    push_lookup(skfi_pkg::OP_INSERT, {mid_key[159:96], mid_key[95:32] + 64'd1, 32'd0});
    push_lookup(skfi_pkg::OP_INSERT, {mid_key[159:96] - 64'd1, {64{1'b1}}, {32{1'b1}}});
    push_lookup(skfi_pkg::OP_FIND, mid_key + 2);
    push_lookup(skfi_pkg::OP_FIND, top_key);
    push_lookup(skfi_pkg::OP_INSERT, top_key - 1);
    push_lookup(skfi_pkg::OP_INSERT, {1'b1, 159'd0});
    push_lookup(skfi_pkg::OP_INSERT, 160'd1);
    push_lookup(skfi_pkg::OP_FIND, 160'd1);
    push_lookup(skfi_pkg::OP_FIND, mid_key - 1);
    wait_idle();

    random_done = 0;
    chunk = 0;
    full_checked = 1'b0;
    while (random_done < RandomLookups) begin
      if (random_done + ChunkSize >= RandomLookups) idle_on = 1'b0;
      for (int i = 0; i < ChunkSize; i++)
        push_lookup(logic'($urandom_range(0, 1)), make_key());
      random_done += ChunkSize;
      // Hold the result side long enough that the block backs up its input.
      if (chunk == 1) long_hold_reqs++;
      chunk++;
      wait_idle();
      if (model_count == skfi_pkg::Capacity && !full_checked) begin
        full_checked = 1'b1;
        push_lookup(skfi_pkg::OP_INSERT, top_key);
        push_lookup(skfi_pkg::OP_FIND, top_key);
        push_lookup(skfi_pkg::OP_INSERT, '0);
        push_lookup(skfi_pkg::OP_INSERT, {shared_prefix[2], 64'd5, 32'd7});
        push_lookup(skfi_pkg::OP_FIND, {shared_prefix[2], 64'd5, 32'd7});
        wait_idle();
      end
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && predicted_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sorted_key_find_or_insert_top.f
design/skfi_pkg.sv
design/skfi_cell.sv
design/skfi_reduce.sv
design/sorted_key_find_or_insert_top.sv
tb/testbench.sv
